// ===== sv/assert_macros.svh =====
// Assertion macros shared by the string decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define JSU_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/jsu_pkg.sv =====
// Shared types and codes for the JSON string decoder.
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
    localparam logic [2:0] ERR_CONTROL   = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_HEX       = 3'd3;
    localparam logic [2:0] ERR_SURROGATE = 3'd4;
    localparam logic [2:0] ERR_END       = 3'd5;

    // Packet queue between the decoder and the serializer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Decoder modes
    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_BODY       = 3'd1,
        MODE_ESC        = 3'd2,
        MODE_HEX_FIRST  = 3'd3,
        MODE_WANT_BSL   = 3'd4,
        MODE_WANT_U     = 3'd5,
        MODE_HEX_SECOND = 3'd6
    } mode_t;

    // All results caused by one source byte
    typedef struct packed {
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      last_idx;  // index of the final result
        logic [1:0]      kind;
        logic [2:0]      code;
    } pkt_t;

endpackage

// ===== sv/json_string_unescape_utf8.sv =====
// Top level of the JSON string literal decoder with UTF-8 output.
//
// Source bytes enter on the s_ stream, one request per byte, s_tlast set on
// the last byte of the source. The block waits for an opening quote, decodes
// the string body (simple escapes, \u quads, surrogate pairs) and sends the
// results on the m_ stream: decoded UTF-8 bytes, a close marker or an error.
// m_tlast marks the final result caused by one source byte; a byte may cause
// none (quote, backslash, partial hex quad) or up to four results.
// Throughput: one source byte per cycle while each byte yields at most one
// result and the receiver takes every result; a code point of n UTF-8 bytes
// holds the output for n results, and a four-entry packet queue between
// decoder and serializer absorbs the burst. A byte's results pass through
// the packet queue and the serializer's packet register on the way to m_.
// When the receiver stalls, the queue fills and s_tready drops once four
// packets wait. Reset clears the parser to idle and empties the queue.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // source_ends
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [4:0] m_tuser,   // [1:0] kind, [4:2] error_code
    output logic       m_tlast    // last_of_run
);

    logic       push;
    logic       push_ready;
    pkt_t       push_pkt;
    logic       pop_valid;
    logic       pop;
    pkt_t       pop_pkt;
    logic [1:0] out_kind;
    logic [2:0] out_code;

    // Parse incoming bytes
    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_ends    (s_tlast),
        .push       (push),
        .push_ready (push_ready),
        .push_pkt   (push_pkt)
    );

    // Buffer packets
    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_pkt   (push_pkt),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_pkt    (pop_pkt)
    );

    // Serialize results
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_pkt   (pop_pkt),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_kind  (out_kind),
        .out_code  (out_code),
        .out_last  (m_tlast)
    );

    assign m_tuser = {out_code, out_kind};

endmodule

// ===== sv/jsu_front.sv =====
// Decoder front end: parses one source byte per cycle, while the queue has room, into a result packet.
`include "assert_macros.svh"
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_ends,
    output logic       push,
    input  logic       push_ready,
    output pkt_t       push_pkt
);

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_F     = 8'h66;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } utf8_t;

    // Hex digit value, bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_digit_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    // Encode a code point as one to four UTF-8 bytes
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.bytes[0] = cp[7:0];
            e.count    = 3'd1;
        end else if (cp <= 21'h7FF) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.count    = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.count    = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.count    = 3'd4;
        end
        return e;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  held_reg, held_next;

    logic        accept;
    logic        failed;
    logic        closed;
    logic [2:0]  err;
    utf8_t       enc;
    logic [4:0]  hex_d;
    logic [15:0] acc_shift;
    logic [20:0] supp_cp;

    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;
    assign hex_d     = hex_digit_val(in_byte);
    assign acc_shift = {acc_reg[11:0], hex_d[3:0]};
    assign supp_cp   = SUPP_BASE + {1'b0, held_reg, acc_shift[9:0]};

    // Decode the byte against the current mode
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        held_next = held_reg;
        failed    = 1'b0;
        closed    = 1'b0;
        err       = ERR_NO_QUOTE;
        enc       = '0;
        case (mode_reg)
            MODE_BODY:
            begin
                if (in_byte == CHAR_QUOTE) closed = 1'b1;
                else if (in_byte < CTRL_LIMIT)
                begin
                    failed = 1'b1;
                    err    = ERR_CONTROL;
                end
                else if (in_byte == CHAR_BSL) mode_next = MODE_ESC;
                else
                begin
                    enc.bytes[0] = in_byte;
                    enc.count    = 3'd1;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_BODY;
                enc.count = 3'd1;
                case (in_byte)
                    CHAR_QUOTE, CHAR_BSL, CHAR_SLASH: enc.bytes[0] = in_byte;
                    CHAR_B: enc.bytes[0] = 8'h08;
                    CHAR_F: enc.bytes[0] = 8'h0C;
                    CHAR_N: enc.bytes[0] = 8'h0A;
                    CHAR_R: enc.bytes[0] = 8'h0D;
                    CHAR_T: enc.bytes[0] = 8'h09;
                    CHAR_U:
                    begin
                        enc.count = 3'd0;
                        mode_next = MODE_HEX_FIRST;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                    default:
                    begin
                        enc.count = 3'd0;
                        failed    = 1'b1;
                        err       = ERR_ESCAPE;
                    end
                endcase
            end
            MODE_HEX_FIRST, MODE_HEX_SECOND:
            begin
                if (hex_d[4])
                begin
                    failed = 1'b1;
                    err    = ERR_HEX;
                end
                else
                begin
                    acc_next = acc_shift;
                    if (cnt_reg != 2'd3) cnt_next = cnt_reg + 2'd1;
                    else
                    begin
                        cnt_next = '0;
                        if (mode_reg == MODE_HEX_FIRST)
                        begin
                            if (acc_shift inside {[HI_SURR_MIN:HI_SURR_MAX]})
                            begin
                                held_next = acc_shift[9:0];
                                mode_next = MODE_WANT_BSL;
                            end
                            else if (acc_shift inside {[LO_SURR_MIN:LO_SURR_MAX]})
                            begin
                                failed = 1'b1;
                                err    = ERR_SURROGATE;
                            end
                            else
                            begin
                                enc       = utf8_encode({5'd0, acc_shift});
                                mode_next = MODE_BODY;
                            end
                        end
                        else if (acc_shift inside {[LO_SURR_MIN:LO_SURR_MAX]})
                        begin
                            enc       = utf8_encode(supp_cp);
                            mode_next = MODE_BODY;
                        end
                        else
                        begin
                            failed = 1'b1;
                            err    = ERR_SURROGATE;
                        end
                    end
                end
            end
            MODE_WANT_BSL:
            begin
                if (in_byte == CHAR_BSL) mode_next = MODE_WANT_U;
                else
                begin
                    failed = 1'b1;
                    err    = ERR_SURROGATE;
                end
            end
            MODE_WANT_U:
            begin
                if (in_byte == CHAR_U)
                begin
                    mode_next = MODE_HEX_SECOND;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                else
                begin
                    failed = 1'b1;
                    err    = ERR_SURROGATE;
                end
            end
            default:
            begin
                if (in_byte == CHAR_QUOTE) mode_next = MODE_BODY;
                else failed = 1'b1;
            end
        endcase

        // Drop all state on error, close or end of source
        if (failed || closed || in_ends)
        begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
            held_next = '0;
        end
    end

    // Build the packet for the queue
    always_comb
    begin
        push_pkt = '0;
        push     = 1'b0;
        if (failed || closed || in_ends)
        begin
            push              = accept;
            push_pkt.last_idx = 2'd0;
            if (failed)
            begin
                push_pkt.kind = KIND_ERROR;
                push_pkt.code = err;
            end
            else if (closed) push_pkt.kind = KIND_CLOSED;
            else
            begin
                push_pkt.kind = KIND_ERROR;
                push_pkt.code = ERR_END;
            end
        end
        else
        begin
            push              = accept && (enc.count != 3'd0);
            push_pkt.bytes    = enc.bytes;
            push_pkt.kind     = KIND_BYTE;
            push_pkt.last_idx = 2'(enc.count - 3'd1);
        end
    end

    // Advance parser state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            held_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            held_reg <= held_next;
        end
    end

    `JSU_ASSERT(a_status_single, (push && push_pkt.kind != KIND_BYTE) |-> (push_pkt.last_idx == 2'd0), "status packet must hold one result")
    `JSU_ASSERT(a_status_idle, (push && push_pkt.kind != KIND_BYTE) |=> (mode_reg == MODE_IDLE), "parser must return to idle after a status result")

endmodule

// ===== sv/jsu_queue.sv =====
// Short packet queue between the decoder and the serializer.
`include "assert_macros.svh"
module jsu_queue
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic push_ready,
    input  pkt_t push_pkt,
    output logic pop_valid,
    input  logic pop,
    output pkt_t pop_pkt
);

    pkt_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_pkt    = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) count_next = count_reg + QCNT_W'(1);
        else if (pop && !push) count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request payload
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= push_pkt;
    end

    `JSU_NEVER(a_no_overflow, push && !push_ready, "push into a full queue")
    `JSU_NEVER(a_no_underflow, pop && !pop_valid, "pop from an empty queue")

endmodule

// ===== sv/jsu_back.sv =====
// Serializer: sends the results of each packet one per cycle while the receiver is ready.
`include "assert_macros.svh"
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop,
    input  pkt_t       pop_pkt,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic [2:0] out_code,
    output logic       out_last
);

    pkt_t       cur_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       beat_done;
    logic       last_beat;

    assign last_beat = (idx_reg == cur_reg.last_idx);
    assign beat_done = busy_reg && out_ready;
    assign pop       = pop_valid && (!busy_reg || (beat_done && last_beat));

    assign out_valid = busy_reg;
    assign out_byte  = cur_reg.bytes[idx_reg];
    assign out_kind  = cur_reg.kind;
    assign out_code  = cur_reg.code;
    assign out_last  = last_beat;

    // Step through the packet, load the next one behind the final result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (beat_done)
        begin
            if (last_beat) busy_reg <= 1'b0;
            else idx_reg <= idx_reg + 2'd1;
        end
    end

    // Hold the packet payload
    always_ff @(posedge clk)
    begin
        if (pop) cur_reg <= pop_pkt;
    end

    `JSU_ASSERT(a_idx_in_range, busy_reg |-> (idx_reg <= cur_reg.last_idx), "result index past end of packet")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the JSON string decoder: directed and random byte streams checked per result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jsu_pkg::*;

    // Source characters with a meaning to the decoder
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [63:0] ESC_LETTERS =
        {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 200;
    localparam int LIMIT_NS      = 5_000_000;

    // One decoded output as seen on the m_ stream
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
        logic       last;
    } decoded_t;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    int tx_idle_pct   = 32;
    int rx_idle_pct   = 79;
    bit rx_hold       = 1'b0;
    int mismatch_count = 0;
    int result_count   = 0;

    // Decoder state mirrored on the bench side
    mode_t       parse_state = MODE_IDLE;
    logic [15:0] hex_acc     = '0;
    logic [1:0]  hex_cnt     = '0;
    logic [9:0]  high_half   = '0;

    decoded_t   decoded_results[$];
    logic [7:0] src_text[$];

    json_string_unescape_utf8 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // Value of a hex digit; bit 4 set when the byte is not one
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    // Decode one accepted source byte and queue the outputs it causes
    function automatic void decode_byte(input logic [7:0] c, input logic ends);
        logic [7:0]  utf8[$];
        logic        failed;
        logic        closed;
        logic        have_cp;
        logic [2:0]  err;
        logic [4:0]  nib;
        logic [20:0] cp;
        decoded_t    r;
        failed  = 1'b0;
        closed  = 1'b0;
        have_cp = 1'b0;
        err     = ERR_NO_QUOTE;
        cp      = '0;
        case (parse_state)
            MODE_BODY:
            begin
                if (c == CH_QUOTE)
                    closed = 1'b1;
                else if (c < 8'h20)
                begin
                    failed = 1'b1;
                    err    = ERR_CONTROL;
                end
                else if (c == CH_BSL)
                    parse_state = MODE_ESC;
                else
                    utf8 = {utf8, c};
            end
            MODE_ESC:
            begin
                parse_state = MODE_BODY;
                case (c)
                    CH_QUOTE, CH_BSL, CH_SLASH: utf8 = {utf8, c};
                    CH_B: utf8 = {utf8, 8'h08};
                    CH_F: utf8 = {utf8, 8'h0c};
                    CH_N: utf8 = {utf8, 8'h0a};
                    CH_R: utf8 = {utf8, 8'h0d};
                    CH_T: utf8 = {utf8, 8'h09};
                    CH_U:
                    begin
                        parse_state = MODE_HEX_FIRST;
                        hex_acc     = '0;
                        hex_cnt     = '0;
                    end
                    default:
                    begin
                        failed = 1'b1;
                        err    = ERR_ESCAPE;
                    end
                endcase
            end
            MODE_HEX_FIRST, MODE_HEX_SECOND:
            begin
                nib = hex_nibble(c);
                if (nib[4])
                begin
                    failed = 1'b1;
                    err    = ERR_HEX;
                end
                else
                begin
                    hex_acc = {hex_acc[11:0], nib[3:0]};
                    if (hex_cnt != 2'd3)
                        hex_cnt = hex_cnt + 2'd1;
                    else
                    begin
                        hex_cnt = '0;
                        if (parse_state == MODE_HEX_FIRST)
                        begin
                            if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff)
                            begin
                                high_half   = hex_acc[9:0];
                                parse_state = MODE_WANT_BSL;
                            end
                            else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff)
                            begin
                                failed = 1'b1;
                                err    = ERR_SURROGATE;
                            end
                            else
                            begin
                                have_cp     = 1'b1;
                                cp          = {5'd0, hex_acc};
                                parse_state = MODE_BODY;
                            end
                        end
                        else if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff)
                        begin
                            failed = 1'b1;
                            err    = ERR_SURROGATE;
                        end
                        else
                        begin
                            // join the pair into one supplementary code point
                            have_cp     = 1'b1;
                            cp          = 21'h10000 + {1'b0, high_half, hex_acc[9:0]};
                            parse_state = MODE_BODY;
                        end
                    end
                end
            end
            MODE_WANT_BSL:
            begin
                if (c == CH_BSL)
                    parse_state = MODE_WANT_U;
                else
                begin
                    failed = 1'b1;
                    err    = ERR_SURROGATE;
                end
            end
            MODE_WANT_U:
            begin
                if (c == CH_U)
                begin
                    parse_state = MODE_HEX_SECOND;
                    hex_acc     = '0;
                    hex_cnt     = '0;
                end
                else
                begin
                    failed = 1'b1;
                    err    = ERR_SURROGATE;
                end
            end
            default:
            begin
                if (c == CH_QUOTE)
                    parse_state = MODE_BODY;
                else
                begin
                    failed = 1'b1;
                    err    = ERR_NO_QUOTE;
                end
            end
        endcase

        // Encode a completed code point as UTF-8
        if (have_cp)
        begin
            if (cp <= 21'h7f)
                utf8 = {utf8, cp[7:0]};
            else if (cp <= 21'h7ff)
            begin
                utf8 = {utf8, 8'hc0 | {3'd0, cp[10:6]}};
                utf8 = {utf8, 8'h80 | {2'd0, cp[5:0]}};
            end
            else if (cp <= 21'hffff)
            begin
                utf8 = {utf8, 8'he0 | {4'd0, cp[15:12]}};
                utf8 = {utf8, 8'h80 | {2'd0, cp[11:6]}};
                utf8 = {utf8, 8'h80 | {2'd0, cp[5:0]}};
            end
            else
            begin
                utf8 = {utf8, 8'hf0 | {5'd0, cp[20:18]}};
                utf8 = {utf8, 8'h80 | {2'd0, cp[17:12]}};
                utf8 = {utf8, 8'h80 | {2'd0, cp[11:6]}};
                utf8 = {utf8, 8'h80 | {2'd0, cp[5:0]}};
            end
        end

        // An error, a close or the end of source yields one marker and drops the bytes
        if (failed || closed || ends)
        begin
            parse_state = MODE_IDLE;
            hex_acc     = '0;
            hex_cnt     = '0;
            high_half   = '0;
            r.data = 8'h00;
            r.last = 1'b1;
            if (failed)
            begin
                r.kind = KIND_ERROR;
                r.code = err;
            end
            else if (closed)
            begin
                r.kind = KIND_CLOSED;
                r.code = '0;
            end
            else
            begin
                r.kind = KIND_ERROR;
                r.code = ERR_END;
            end
            decoded_results = {decoded_results, r};
        end
        else
        begin
            foreach (utf8[i])
            begin
                r.data = utf8[i];
                r.kind = KIND_BYTE;
                r.code = '0;
                r.last = (i == utf8.size() - 1);
                decoded_results = {decoded_results, r};
            end
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR: result %0d: %s is %0h, want %0h", result_count, field, got, want);
        mismatch_count++;
    endtask

    // Offer one source byte, with random gaps, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic ends);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= ends;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_byte(b, ends);
    endtask

    task automatic send_text(input string s, input bit ends_last);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], ends_last && (i == s.len() - 1));
    endtask

    // Send the text buffer, stopping after the byte that marks the end of source
    task automatic send_buffer(input int ends_at, output int count);
        int i;
        count = 0;
        for (i = 0; i < src_text.size(); i++)
        begin
            send_byte(src_text[i], i == ends_at);
            count++;
            if (i == ends_at)
                break;
        end
    endtask

    // Stop offering and wait until every expected output has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (decoded_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Append one byte to the text buffer
    function automatic void append_src(input logic [7:0] b);
        src_text = {src_text, b};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'd0, n};
        if ($urandom_range(1) == 0)
            return 8'h41 + {4'd0, n} - 8'd10;
        return 8'h61 + {4'd0, n} - 8'd10;
    endfunction

    function automatic void push_quad(input logic [15:0] v);
        append_src(CH_BSL);
        append_src(CH_U);
        append_src(hex_char(v[15:12]));
        append_src(hex_char(v[11:8]));
        append_src(hex_char(v[7:4]));
        append_src(hex_char(v[3:0]));
    endfunction

    function automatic void push_non_hex();
        logic [7:0] ch;
        logic [4:0] nib;
        do
        begin
            ch  = 8'($urandom);
            nib = hex_nibble(ch);
        end
        while (!nib[4]);
        append_src(ch);
    endfunction

    // Build one string literal with random content, sometimes broken partway
    function automatic void build_random_string();
        int          n_elem;
        int          i;
        int          pick;
        bit          broken;
        logic [7:0]  ch;
        logic [15:0] cp;
        src_text.delete();
        broken = 1'b0;
        // stray byte while idle
        if ($urandom_range(9) == 0)
        begin
            do ch = 8'($urandom); while (ch == CH_QUOTE);
            append_src(ch);
        end
        append_src(CH_QUOTE);
        n_elem = $urandom_range(6);
        for (i = 0; i < n_elem && !broken; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 36)
            begin
                do ch = 8'($urandom_range(8'hff, 8'h20));
                while (ch == CH_QUOTE || ch == CH_BSL);
                append_src(ch);
            end
            else if (pick < 54)
            begin
                append_src(CH_BSL);
                append_src(ESC_LETTERS[8 * $urandom_range(7) +: 8]);
            end
            else if (pick < 70)
            begin
                // one, two or three UTF-8 bytes
                case ($urandom_range(2))
                    0: cp = 16'($urandom_range(16'h007f));
                    1: cp = 16'($urandom_range(16'h07ff, 16'h0080));
                    default:
                    begin
                        do cp = 16'($urandom_range(16'hffff, 16'h0800));
                        while (cp >= 16'hd800 && cp <= 16'hdfff);
                    end
                endcase
                push_quad(cp);
            end
            else if (pick < 88)
            begin
                push_quad(16'($urandom_range(16'hdbff, 16'hd800)));
                push_quad(16'($urandom_range(16'hdfff, 16'hdc00)));
            end
            else
            begin
                broken = 1'b1;
                case ($urandom_range(7))
                    0: append_src(8'($urandom_range(8'h1f)));
                    1:
                    begin
                        append_src(CH_BSL);
                        do ch = 8'($urandom);
                        while (ch == CH_QUOTE || ch == CH_BSL || ch == CH_SLASH ||
                               ch == CH_B || ch == CH_F || ch == CH_N ||
                               ch == CH_R || ch == CH_T || ch == CH_U);
                        append_src(ch);
                    end
                    2:
                    begin
                        append_src(CH_BSL);
                        append_src(CH_U);
                        repeat ($urandom_range(3))
                            append_src(hex_char(4'($urandom)));
                        push_non_hex();
                    end
                    3: push_quad(16'($urandom_range(16'hdfff, 16'hdc00)));
                    4:
                    begin
                        push_quad(16'($urandom_range(16'hdbff, 16'hd800)));
                        do ch = 8'($urandom); while (ch == CH_BSL);
                        append_src(ch);
                    end
                    5:
                    begin
                        push_quad(16'($urandom_range(16'hdbff, 16'hd800)));
                        append_src(CH_BSL);
                        do ch = 8'($urandom); while (ch == CH_U);
                        append_src(ch);
                    end
                    6:
                    begin
                        // second quad outside the low surrogate range
                        push_quad(16'($urandom_range(16'hdbff, 16'hd800)));
                        do cp = 16'($urandom); while (cp >= 16'hdc00 && cp <= 16'hdfff);
                        push_quad(cp);
                    end
                    default:
                    begin
                        push_quad(16'($urandom_range(16'hdbff, 16'hd800)));
                        append_src(CH_BSL);
                        append_src(CH_U);
                        repeat ($urandom_range(3))
                            append_src(hex_char(4'($urandom)));
                        push_non_hex();
                    end
                endcase
            end
        end
        if (!broken)
            append_src(CH_QUOTE);
    endfunction

    // Bytes outside a string, a string cut at once, and a close on the last byte
    task automatic test_idle_and_open();
        send_byte(8'hff, 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        drain();
    endtask

    // Plain bytes at the range limits, then a raw control byte
    task automatic test_body_bytes();
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        drain();
    endtask

    task automatic test_escapes();
        send_text("\"\\t\\q", 1'b0);
        drain();
    endtask

    // Code point zero, a surrogate pair in mixed case, then a bad hex digit
    task automatic test_unicode_quads();
        send_text("\"\\u0000\\uD83d\\uDE00\\u0g", 1'b0);
        drain();
    endtask

    // Lone low surrogate, then end of source on a byte that would decode
    task automatic test_surrogate_and_end();
        send_text("\"\\uDC00", 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'hff, 1'b1);
        drain();
    endtask

    task automatic test_random_strings(input int n_bytes);
        int sent;
        int count;
        int pick;
        int ends_at;
        sent = 0;
        while (sent < n_bytes)
        begin
            build_random_string();
            pick = $urandom_range(99);
            if (pick < 12)
                ends_at = $urandom_range(src_text.size() - 1);
            else if (pick < 30)
                ends_at = src_text.size() - 1;
            else
                ends_at = -1;
            send_buffer(ends_at, count);
            sent += count;
        end
        drain();
    endtask

    // Hold the output for a long stretch while multi-byte code points keep arriving
    task automatic test_output_backpressure();
        int count;
        src_text.delete();
        append_src(CH_QUOTE);
        repeat (3)
        begin
            push_quad(16'($urandom_range(16'hdbff, 16'hd800)));
            push_quad(16'($urandom_range(16'hdfff, 16'hdc00)));
            push_quad(16'($urandom_range(16'hd7ff, 16'h0800)));
        end
        append_src(CH_QUOTE);
        fork
            begin
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            send_buffer(-1, count);
        join
        drain();
    endtask

    // Drive the output ready with random stalls
    always @(posedge clk)
        m_tready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    // Compare each output request with the oldest expected one
    always @(posedge clk)
    begin : check_results
        decoded_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_results.size() == 0)
                report_mismatch("unexpected result, data", m_tdata, 8'h00);
            else
            begin
                want = decoded_results.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch("out_byte", m_tdata, want.data);
                if (m_tuser[1:0] !== want.kind)
                    report_mismatch("kind", {6'd0, m_tuser[1:0]}, {6'd0, want.kind});
                if (m_tuser[4:2] !== want.code)
                    report_mismatch("error_code", {5'd0, m_tuser[4:2]}, {5'd0, want.code});
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", {7'd0, m_tlast}, {7'd0, want.last});
            end
            result_count++;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_open();
        test_body_bytes();
        test_escapes();
        test_unicode_quads();
        test_surrogate_and_end();
        test_random_strings(90);

        tx_idle_pct = 79;
        rx_idle_pct = 32;
        test_random_strings(90);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_strings(75);
        test_output_backpressure();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
